// ===== rtl/mcd_pkg.sv =====
// Package for the Morse code decoder: constants, types and the code lookup table.
package mcd_pkg;

    // Longest symbol code that can still match
    localparam int MCD_MAX_SYMBOLS = 6;
    localparam int MCD_LEN_W       = $clog2(MCD_MAX_SYMBOLS + 1);
    localparam int MCD_TBL_BITS    = 8;
    localparam int MCD_TBL_N       = 50;

    // Byte codes
    localparam logic [7:0] MCD_CHAR_CR    = 8'h0D;
    localparam logic [7:0] MCD_CHAR_LF    = 8'h0A;
    localparam logic [7:0] MCD_CHAR_SPACE = 8'h20;
    localparam logic [7:0] MCD_CHAR_SLASH = 8'h2F;
    localparam logic [7:0] MCD_CHAR_DOT   = 8'h2E;
    localparam logic [7:0] MCD_CHAR_DASH  = 8'h2D;

    // One table entry: character, symbol count, symbols ('-' = 1, first symbol MSB)
    typedef struct packed {
        logic [7:0]              ch;
        logic [3:0]              len;
        logic [MCD_TBL_BITS-1:0] bits;
    } t_entry;

    // Up to two result words produced by one input word
    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] ch0;
        logic [7:0] ch1;
    } t_res;

    // Result of a table lookup
    typedef struct packed {
        logic       hit;
        logic [7:0] ch;
    } t_match;

    localparam t_entry MCD_TABLE [MCD_TBL_N] = '{
        '{"A", 4'd2, 8'b00000001}, '{"B", 4'd4, 8'b00001000},
        '{"C", 4'd4, 8'b00001010}, '{"D", 4'd3, 8'b00000100},
        '{"E", 4'd1, 8'b00000000}, '{"F", 4'd4, 8'b00000010},
        '{"G", 4'd3, 8'b00000110}, '{"H", 4'd4, 8'b00000000},
        '{"I", 4'd2, 8'b00000000}, '{"J", 4'd4, 8'b00000111},
        '{"K", 4'd3, 8'b00000101}, '{"L", 4'd4, 8'b00000100},
        '{"M", 4'd2, 8'b00000011}, '{"N", 4'd2, 8'b00000010},
        '{"O", 4'd3, 8'b00000111}, '{"P", 4'd4, 8'b00000110},
        '{"Q", 4'd4, 8'b00001101}, '{"R", 4'd3, 8'b00000010},
        '{"S", 4'd3, 8'b00000000}, '{"T", 4'd1, 8'b00000001},
        '{"U", 4'd3, 8'b00000001}, '{"V", 4'd4, 8'b00000001},
        '{"W", 4'd3, 8'b00000011}, '{"X", 4'd4, 8'b00001001},
        '{"Y", 4'd4, 8'b00001011}, '{"Z", 4'd4, 8'b00001100},
        '{"0", 4'd5, 8'b00011111}, '{"1", 4'd5, 8'b00001111},
        '{"2", 4'd5, 8'b00000111}, '{"3", 4'd5, 8'b00000011},
        '{"4", 4'd5, 8'b00000001}, '{"5", 4'd5, 8'b00000000},
        '{"6", 4'd5, 8'b00010000}, '{"7", 4'd5, 8'b00011000},
        '{"8", 4'd5, 8'b00011100}, '{"9", 4'd5, 8'b00011110},
        '{".", 4'd6, 8'b00010101}, '{",", 4'd6, 8'b00110011},
        '{"?", 4'd6, 8'b00001100}, '{"!", 4'd6, 8'b00101011},
        '{":", 4'd6, 8'b00111000}, '{";", 4'd6, 8'b00101010},
        '{"=", 4'd5, 8'b00010001}, '{"-", 4'd6, 8'b00100001},
        '{"+", 4'd5, 8'b00001010}, '{"_", 4'd6, 8'b00001101},
        '{"(", 4'd5, 8'b00010110}, '{")", 4'd6, 8'b00101101},
        '{"/", 4'd5, 8'b00010010}, '{"@", 4'd6, 8'b00011010}
    };

    // Parallel compare of a closed code against every table entry
    function automatic t_match mcd_lookup(input logic [MCD_LEN_W-1:0] len,
                                          input logic [MCD_MAX_SYMBOLS-1:0] pat);
        t_match m;
        m.hit = 1'b0;
        m.ch  = '0;
        for (int i = 0; i < MCD_TBL_N; i++) begin
            if ((4'(len) == MCD_TABLE[i].len) &&
                (MCD_TBL_BITS'(pat) == MCD_TABLE[i].bits)) begin
                m.hit = 1'b1;
                m.ch  = MCD_TABLE[i].ch;
            end
        end
        return m;
    endfunction

endpackage

// ===== rtl/mcd_core.sv =====
// Decode core: pending code state, symbol handling and table lookup per word.
module mcd_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,      // registered word is consumed this cycle
    input  logic [7:0]  i_byte,
    input  logic        i_eom,
    output mcd_pkg::t_res o_res
);
    import mcd_pkg::*;

    logic [MCD_MAX_SYMBOLS-1:0] r_pat, n_pat;
    logic [MCD_LEN_W-1:0]       r_len, n_len;
    logic                       r_inv, n_inv;
    logic [1:0]                 r_run, n_run;

    logic                       is_crlf, is_space, is_slash, is_sym, is_mark;
    logic                       pending, close1, emit_space, closing, char_ok;
    logic [1:0]                 run_inc;
    logic [MCD_MAX_SYMBOLS-1:0] a_pat, sel_pat;
    logic [MCD_LEN_W-1:0]       a_len, sel_len;
    logic                       a_inv, sel_inv;
    t_match                     match;

    // Byte classification
    assign is_crlf  = (i_byte == MCD_CHAR_CR) || (i_byte == MCD_CHAR_LF);
    assign is_space = (i_byte == MCD_CHAR_SPACE);
    assign is_slash = (i_byte == MCD_CHAR_SLASH);
    assign is_sym   = !is_crlf && !is_space && !is_slash;
    assign is_mark  = (i_byte == MCD_CHAR_DOT) || (i_byte == MCD_CHAR_DASH);

    assign pending    = (r_len != '0) || r_inv;
    assign run_inc    = r_run + 2'd1;
    assign close1     = (is_space && (run_inc == 2'd1) && pending) || is_slash;
    assign emit_space = is_slash || (is_space && (run_inc == 2'd3));

    // Code after this byte's own action
    always_comb begin
        a_pat = r_pat;
        a_len = r_len;
        a_inv = r_inv;
        if (close1) begin
            a_pat = '0;
            a_len = '0;
            a_inv = 1'b0;
        end else if (is_sym) begin
            if (r_len >= MCD_LEN_W'(MCD_MAX_SYMBOLS)) begin
                a_inv = 1'b1;
            end else begin
                a_len = r_len + MCD_LEN_W'(1);
                a_pat = {r_pat[MCD_MAX_SYMBOLS-2:0], (i_byte == MCD_CHAR_DASH)};
                a_inv = r_inv | !is_mark;
            end
        end
    end

    // One close at most carries a code: the byte's own or the end-mark flush
    assign closing = close1 || i_eom;
    assign sel_pat = close1 ? r_pat : a_pat;
    assign sel_len = close1 ? r_len : a_len;
    assign sel_inv = close1 ? r_inv : a_inv;
    assign match   = mcd_lookup(sel_len, sel_pat);
    assign char_ok = closing && !sel_inv && match.hit;

    // Result list: character first, then word space
    always_comb begin
        o_res.cnt = {1'b0, char_ok} + {1'b0, emit_space};
        o_res.ch0 = char_ok ? match.ch : MCD_CHAR_SPACE;
        o_res.ch1 = MCD_CHAR_SPACE;
    end

    // Next state
    always_comb begin
        n_pat = a_pat;
        n_len = a_len;
        n_inv = a_inv;
        if (is_crlf) begin
            n_run = r_run;
        end else if (is_space) begin
            if (close1) begin
                n_run = 2'd1;
            end else if (run_inc == 2'd3) begin
                n_run = 2'd0;
            end else begin
                n_run = run_inc;
            end
        end else begin
            n_run = 2'd0;
        end
        if (i_eom) begin
            n_pat = '0;
            n_len = '0;
            n_inv = 1'b0;
            n_run = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat <= '0;
            r_len <= '0;
            r_inv <= 1'b0;
            r_run <= 2'd0;
        end else if (i_take) begin
            r_pat <= n_pat;
            r_len <= n_len;
            r_inv <= n_inv;
            r_run <= n_run;
        end
    end

    // Checks
    a_run_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run != 2'd3) else $error("space run out of range");
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= MCD_LEN_W'(MCD_MAX_SYMBOLS)) else $error("code length overrun");
    a_eom_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_eom) |=> (r_len == '0 && !r_inv && r_run == 2'd0))
        else $error("state not cleared after end mark");
    a_run_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run != 2'd0) |-> (r_len == '0 && !r_inv))
        else $error("pending code during space run");

endmodule

// ===== rtl/mcd_outbuf.sv =====
// Two-entry result buffer that feeds the output stream one word at a time.
module mcd_outbuf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  mcd_pkg::t_res i_res,
    output logic          o_can_load,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [7:0]    o_m_tdata,   // [7:0] text_char
    output logic          o_m_tlast    // last_in_run
);
    import mcd_pkg::*;

    logic [1:0] r_cnt;
    logic [7:0] r_ch0, r_ch1;
    logic       r_last0;
    logic       fire;

    assign fire       = o_m_tvalid && i_m_tready;
    assign o_can_load = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_m_tready);
    assign o_m_tvalid = (r_cnt != 2'd0);
    assign o_m_tdata  = r_ch0;
    assign o_m_tlast  = r_last0;

    // Count of held words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_res.cnt;
        end else if (fire) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // Payload: load replaces both entries, a send shifts the second down
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ch0   <= i_res.ch0;
            r_ch1   <= i_res.ch1;
            r_last0 <= (i_res.cnt == 2'd1);
        end else if (fire) begin
            r_ch0   <= r_ch1;
            r_last0 <= 1'b1;
        end
    end

    // Checks
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("result count out of range");
    a_two_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !r_last0) else $error("last flag on first of two");
    a_load_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && r_cnt != 2'd0) |-> (r_cnt == 2'd1 && fire))
        else $error("load over a pending word");

endmodule

// ===== rtl/morse_code_decoder.sv =====
// Morse code decoder top level: input register, decode core and result buffer.
// Throughput: one input word per cycle while each yields at most one result and
// the output takes words without stalling; a word that yields two results (code
// closed by '/') holds the single output port for both words. Reset (i_rst_n low,
// synchronous) clears the pending code, the space count and both buffers.
module morse_code_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] symbol_byte
    input  logic       i_s_tlast,   // end_of_message
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] text_char
    output logic       o_m_tlast    // last_in_run
);
    import mcd_pkg::*;

    logic       r_vld;
    logic [7:0] r_byte;
    logic       r_eom;
    logic       take, can_load, load;
    t_res       res;

    // Registered word advances when it yields nothing or the buffer has room
    assign take       = r_vld && ((res.cnt == 2'd0) || can_load);
    assign load       = take && (res.cnt != 2'd0);
    assign o_s_tready = !r_vld || take;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_byte <= i_s_tdata;
            r_eom  <= i_s_tlast;
        end
    end

    mcd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (r_byte),
        .i_eom   (r_eom),
        .o_res   (res)
    );

    mcd_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_res      (res),
        .o_can_load (can_load),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ===== sim/mcd_checker.sv =====
// Checker for the Morse decoder: watches both streams, predicts the text and compares.
`timescale 1ns / 1ps

module mcd_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] symbol_byte
    input  logic       i_s_tlast,   // end_of_message
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,   // [7:0] text_char
    input  logic       i_m_tlast,   // last_in_run
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);
    import mcd_pkg::*;

    typedef struct {
        logic [7:0] text_char;
        logic       last_in_run;
    } t_text_word;

    // Decoded characters still owed by the block, oldest first
    t_text_word text_due [$];
    // Characters produced by the input word being predicted
    logic [7:0] step_chars [$];

    // Predictor state
    logic [MCD_MAX_SYMBOLS-1:0] code_bits;
    logic [MCD_LEN_W-1:0]       code_len;
    logic                       code_bad;
    logic [1:0]                 spaces_seen;

    int fails = 0;
    int checked = 0;

    // Character for a symbol code, or 0 when no table entry holds it.
    // Codes are listed in the order of the letters string, '-' counts as 1.
    function automatic logic [7:0] morse_char(input int len,
                                              input logic [MCD_MAX_SYMBOLS-1:0] bits);
        string      codes;
        string      letters;
        int         idx;
        int         n;
        int         acc;
        logic [7:0] found;
        codes = {".- -... -.-. -.. . ..-. --. .... .. .--- -.- .-.. -- -. --- ",
                 ".--. --.- .-. ... - ..- ...- .-- -..- -.-- --.. ",
                 "----- .---- ..--- ...-- ....- ..... -.... --... ---.. ----. ",
                 ".-.-.- --..-- ..--.. -.-.-- ---... -.-.-. -...- -....- ",
                 ".-.-. ..--.- -.--. -.--.- -..-. .--.-. "};
        letters = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.,?!:;=-+_()/@";
        found = 8'h00;
        idx   = 0;
        n     = 0;
        acc   = 0;
        for (int i = 0; i < codes.len(); i++) begin
            if (codes[i] == " ") begin
                if (n == len && acc == int'(bits)) begin
                    found = letters[idx];
                end
                idx++;
                n   = 0;
                acc = 0;
            end else begin
                acc = (acc << 1) | ((codes[i] == "-") ? 1 : 0);
                n++;
            end
        end
        return found;
    endfunction

    // Close the pending code: a known, clean code yields its character
    task close_code();
        logic [7:0] c;
        if ((code_len != 0) && !code_bad) begin
            c = morse_char(int'(code_len), code_bits);
            if (c != 8'h00) begin
                step_chars.push_back(c);
            end
        end
        code_bits = '0;
        code_len  = '0;
        code_bad  = 1'b0;
    endtask

    // Expected text for one accepted input word
    task predict_text(input logic [7:0] b, input logic eom);
        int         run;
        t_text_word w;
        step_chars.delete();
        if (b == MCD_CHAR_SPACE) begin
            run = int'(spaces_seen) + 1;
            if (run == 1 && (code_len != 0 || code_bad)) begin
                close_code();
            end else if (run >= 3) begin
                step_chars.push_back(MCD_CHAR_SPACE);
                run = 0;
            end
            spaces_seen = 2'(run);
        end else if (b == MCD_CHAR_SLASH) begin
            close_code();
            step_chars.push_back(MCD_CHAR_SPACE);
            spaces_seen = '0;
        end else if (b != MCD_CHAR_CR && b != MCD_CHAR_LF) begin
            // any other byte is a symbol; only dots and dashes keep the code valid
            spaces_seen = '0;
            if (int'(code_len) >= MCD_MAX_SYMBOLS) begin
                code_bad = 1'b1;
            end else begin
                code_len  = code_len + 1'b1;
                code_bits = {code_bits[MCD_MAX_SYMBOLS-2:0], (b == MCD_CHAR_DASH)};
                if (b != MCD_CHAR_DOT && b != MCD_CHAR_DASH) begin
                    code_bad = 1'b1;
                end
            end
        end
        // end of message flushes whatever is pending
        if (eom) begin
            close_code();
            spaces_seen = '0;
        end
        for (int i = 0; i < step_chars.size(); i++) begin
            w.text_char   = step_chars[i];
            w.last_in_run = (i == step_chars.size() - 1);
            text_due.push_back(w);
        end
    endtask

    // Compare output words, then predict from input words
    always @(posedge i_clk) begin
        t_text_word want;
        if (!i_rst_n) begin
            code_bits   = '0;
            code_len    = '0;
            code_bad    = 1'b0;
            spaces_seen = '0;
            text_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                checked++;
                if (text_due.size() == 0) begin
                    $error("text_char: expected nothing, got 0x%02h", i_m_tdata);
                    fails++;
                end else begin
                    want = text_due.pop_front();
                    if (i_m_tdata !== want.text_char) begin
                        $error("text_char: expected 0x%02h, got 0x%02h",
                               want.text_char, i_m_tdata);
                        fails++;
                    end
                    if (i_m_tlast !== want.last_in_run) begin
                        $error("last_in_run: expected %0b, got %0b",
                               want.last_in_run, i_m_tlast);
                        fails++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_text(i_s_tdata, i_s_tlast);
            end
        end
        o_pending    = text_due.size();
        o_fail_count = fails;
        o_checked    = checked;
    end

endmodule

// ===== sim/testbench.sv =====
// Testbench top for the Morse decoder: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module testbench;
    import mcd_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_BURSTY} t_idle_mode;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] symbol_byte
    logic       s_tlast;    // end_of_message
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [7:0] text_char
    logic       m_tlast;    // last_in_run

    int fail_count;
    int pending;
    int checked;

    int         n_counted;
    int         n_ignored;
    t_idle_mode src_mode;
    t_idle_mode dst_mode;

    morse_code_decoder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    mcd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // 100 MHz clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Hard stop if the decoder hangs
    initial begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Wait cycles before the next word, by idle mode
    function automatic int draw_gap(input t_idle_mode mode);
        int gap;
        case (mode)
            IDLE_NONE: gap = 0;
            IDLE_FULL: gap = $urandom_range(0, 18);
            default:   gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 18) : 0;
        endcase
        return gap;
    endfunction

    // Present one word at the falling edge and hold it until accepted
    task automatic send_word(input logic [7:0] b, input logic eom);
        int gap;
        gap = draw_gap(src_mode);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eom;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        if (b == MCD_CHAR_CR || b == MCD_CHAR_LF) begin
            n_ignored++;
        end else begin
            n_counted++;
        end
    endtask

    task automatic send_text(input string s, input bit eom_on_last);
        for (int i = 0; i < s.len(); i++) begin
            send_word(s[i], eom_on_last && (i == s.len() - 1));
        end
    endtask

    // Output side: random stall before taking each word
    initial begin
        int gap;
        int taken;
        int next_switch;
        m_tready    = 1'b0;
        dst_mode    = IDLE_NONE;
        taken       = 0;
        next_switch = 50;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (taken >= next_switch) begin
                dst_mode    = t_idle_mode'($urandom_range(0, 2));
                next_switch = taken + $urandom_range(30, 100);
            end
            gap = draw_gap(dst_mode);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            taken++;
        end
    end

    // Input side: reset, directed words, then random Morse text
    initial begin
        int         pick;
        int         len;
        int         sep;
        int         next_switch;
        logic [7:0] sym;
        logic       eom;
        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        s_tlast     = 1'b0;
        n_counted   = 0;
        n_ignored   = 0;
        src_mode    = IDLE_NONE;
        next_switch = 60;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // letter, then second and third space for a word space
        send_text(". ", 1'b0);
        send_text("  ", 1'b0);
        // slash closes a code and adds a space
        send_text("-/", 1'b0);
        // stray bytes spoil the code, the closing space gives nothing
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(MCD_CHAR_SPACE, 1'b0);
        send_word(MCD_CHAR_CR, 1'b0);
        // end mark flushes a digit
        send_text("---..", 1'b1);
        send_word(MCD_CHAR_LF, 1'b1);
        // seven symbols overflow the code; slash alone gives only the space
        send_text("-.-.--.", 1'b0);
        send_word(MCD_CHAR_SLASH, 1'b0);
        // end mark on a line break still flushes
        send_text(".", 1'b0);
        send_word(MCD_CHAR_CR, 1'b1);

        while (n_counted < 1400) begin
            if (n_counted >= next_switch) begin
                src_mode    = t_idle_mode'($urandom_range(0, 2));
                next_switch = n_counted + $urandom_range(40, 120);
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                // a code of random dots and dashes, now and then overlong or spoiled
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 8)
                                                   : $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 49) == 0) begin
                        sym = 8'($urandom_range(0, 255));
                    end else begin
                        sym = $urandom_range(0, 1) ? MCD_CHAR_DASH : MCD_CHAR_DOT;
                    end
                    if ($urandom_range(0, 29) == 0) begin
                        send_word($urandom_range(0, 1) ? MCD_CHAR_CR : MCD_CHAR_LF, 1'b0);
                    end
                    eom = (k == len - 1) && ($urandom_range(0, 9) == 0);
                    send_word(sym, eom);
                end
                sep = $urandom_range(0, 9);
                if (sep < 4) begin
                    send_word(MCD_CHAR_SPACE, 1'b0);
                end else if (sep < 6) begin
                    send_word(MCD_CHAR_SLASH, 1'b0);
                end else if (sep < 8) begin
                    send_text("   ", 1'b0);
                end else if (sep == 9) begin
                    send_word(MCD_CHAR_SPACE, 1'b1);
                end
            end else if (pick < 82) begin
                len = $urandom_range(1, 5);
                for (int k = 0; k < len; k++) begin
                    send_word(MCD_CHAR_SPACE, $urandom_range(0, 24) == 0);
                end
            end else if (pick < 90) begin
                send_word(MCD_CHAR_SLASH, $urandom_range(0, 24) == 0);
            end else if (pick < 95) begin
                send_word($urandom_range(0, 1) ? MCD_CHAR_CR : MCD_CHAR_LF,
                          $urandom_range(0, 24) == 0);
            end else begin
                send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end
        s_tvalid <= 1'b0;

        // drain outstanding text, then a few quiet cycles
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        $display("Sent %0d Morse words plus %0d line breaks; checked %0d text words.",
                 n_counted, n_ignored, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mcd_pkg.sv
rtl/mcd_core.sv
rtl/mcd_outbuf.sv
rtl/morse_code_decoder.sv
sim/mcd_checker.sv
sim/testbench.sv
